FILE: hdl/prl_pkg.sv
// Shared types, codes, reset values and helper functions for the PIN retry limiter.
// No dependencies; every other file in hdl uses this package.
package prl_pkg;

    localparam int unsigned PIN_W   = 48;
    localparam int unsigned TIME_W  = 48;
    localparam int unsigned CNT_W   = 4;
    localparam int unsigned DLY_W   = 32;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 48;

    localparam logic [CNT_W-1:0] FAIL_MAX = 4'd15;

    localparam logic [PIN_W-1:0] RST_FACTORY_PIN = 48'h0;
    localparam logic [CNT_W-1:0] RST_FREE_ATT    = 4'd3;
    localparam logic [CNT_W-1:0] RST_LOCK_LIMIT  = 4'd10;
    localparam logic [DLY_W-1:0] RST_BASE_MS     = 32'd60000;
    localparam logic [DLY_W-1:0] RST_CAP_MS      = 32'd3600000;

    localparam logic [PIN_W-1:0] PIN_ASCENDING   = 48'h313233343536;
    localparam logic [PIN_W-1:0] PIN_DESCENDING  = 48'h363534333231;
    localparam logic [7:0]       ASCII_ZERO      = 8'h30;
    localparam logic [7:0]       ASCII_NINE      = 8'h39;

    typedef enum logic [1:0] {
        ACT_VERIFY = 2'd0,
        ACT_CHANGE = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_QUERY  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_LOCKED  = 2'd1,
        ST_RATE    = 2'd2,
        ST_INVALID = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FACTORY_PIN = 3'd0,
        CFG_FREE_ATT    = 3'd1,
        CFG_LOCK_LIMIT  = 3'd2,
        CFG_BASE_MS     = 3'd3,
        CFG_CAP_MS      = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [PIN_W-1:0] factory_pin;
        logic [CNT_W-1:0] free_att;
        logic [CNT_W-1:0] lock_limit;
        logic [DLY_W-1:0] base_ms;
        logic [DLY_W-1:0] cap_ms;
    } t_cfg;

    // Six ASCII digits, not all the same, and neither 123456 nor 654321.
    function automatic logic pin_fmt_ok(input logic [PIN_W-1:0] code);
        logic       digits;
        logic       same;
        logic [7:0] c;
        digits = 1'b1;
        same   = 1'b1;
        for (int k = 0; k < 6; k++) begin
            c = code[PIN_W-1-8*k -: 8];
            if (c < ASCII_ZERO || c > ASCII_NINE) begin
                digits = 1'b0;
            end
            if (c != code[PIN_W-1 -: 8]) begin
                same = 1'b0;
            end
        end
        return digits && !same && code != PIN_ASCENDING && code != PIN_DESCENDING;
    endfunction

    // Remaining wait: doublings = min(count, limit) - free, clamped to the cap once exceeded.
    function automatic logic [DLY_W-1:0] calc_delay(
        input logic              lock,
        input logic [CNT_W-1:0]  fcnt,
        input logic [TIME_W-1:0] last,
        input logic [TIME_W-1:0] now,
        input t_cfg              cfg
    );
        logic [CNT_W-1:0]  top;
        logic [CNT_W-1:0]  nsh;
        logic [TIME_W-1:0] shifted;
        logic [TIME_W-1:0] elapsed;
        logic [DLY_W-1:0]  backoff;
        logic [DLY_W-1:0]  result;
        top = (fcnt < cfg.lock_limit) ? fcnt : cfg.lock_limit;
        nsh = (top > cfg.free_att) ? top - cfg.free_att : '0;
        shifted = {{(TIME_W-DLY_W){1'b0}}, cfg.base_ms} << nsh;
        if (nsh != '0 && shifted > {{(TIME_W-DLY_W){1'b0}}, cfg.cap_ms}) begin
            backoff = cfg.cap_ms;
        end else begin
            backoff = shifted[DLY_W-1:0];
        end
        elapsed = (now >= last) ? now - last : '0;
        if (lock) begin
            result = '1;
        end else if (fcnt < cfg.free_att) begin
            result = '0;
        end else if (elapsed >= {{(TIME_W-DLY_W){1'b0}}, backoff}) begin
            result = '0;
        end else begin
            result = backoff - elapsed[DLY_W-1:0];
        end
        return result;
    endfunction

endpackage

FILE: hdl/prl_req_if.sv
// Request channel of the PIN retry limiter: valid/ready plus request payload.
// Depends on prl_pkg for field widths.
interface prl_req_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 action;
    logic [prl_pkg::PIN_W-1:0]  pin_code;
    logic [prl_pkg::PIN_W-1:0]  new_code;
    logic [prl_pkg::TIME_W-1:0] now_ms;

    modport source (output valid, action, pin_code, new_code, now_ms, input ready);
    modport sink   (input valid, action, pin_code, new_code, now_ms, output ready);
endinterface

FILE: hdl/prl_rsp_if.sv
// Response channel of the PIN retry limiter: valid/ready plus response payload.
// Depends on prl_pkg for field widths.
interface prl_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                status;
    logic [prl_pkg::DLY_W-1:0] retry_delay_ms;
    logic [prl_pkg::CNT_W-1:0] failures;
    logic                      locked;

    modport source (output valid, status, retry_delay_ms, failures, locked, input ready);
    modport sink   (input valid, status, retry_delay_ms, failures, locked, output ready);
endinterface

FILE: hdl/pin_retry_limiter_unit.sv
// PIN retry limiter top level: failure counter, doubling backoff, lockout, PIN change.
// Depends on prl_pkg, prl_req_if and prl_rsp_if.
//
//  channel   dir  handshake     payload
//  i_req     in   valid/ready   action, pin_code, new_code, now_ms
//  o_rsp     out  valid/ready   status, retry_delay_ms, failures, locked
//  i_cfg_*   in   write enable  i_cfg_idx selects register, i_cfg_data holds value
//
// One request per cycle sustained unless o_rsp stalls; o_rsp.valid rises as it reaches stage 2.
// Stage 0 registers the request, stage 1 holds the post-update state snapshot after the
// verify/update logic, stage 2 is the response register fed by the delay computation.
// Each stage advances when the next one is empty or moving, so o_rsp stalls fill back one
// stage at a time. Synchronous active-low reset clears state and configuration to defaults.
module pin_retry_limiter_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [prl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [prl_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    prl_req_if.sink                        i_req,
    prl_rsp_if.source                      o_rsp
);

    prl_pkg::t_cfg r_cfg;

    logic [prl_pkg::CNT_W-1:0]    r_fcnt, n_fcnt;
    logic [prl_pkg::TIME_W-1:0]   r_last, n_last;
    logic                         r_lock, n_lock;
    logic [prl_pkg::PIN_W-1:0]    r_chg_pin, n_chg_pin;
    logic                         r_pin_chg, n_pin_chg;

    logic                         r_s0_vld;
    prl_pkg::t_action             r_s0_act;
    logic [prl_pkg::PIN_W-1:0]    r_s0_pin;
    logic [prl_pkg::PIN_W-1:0]    r_s0_new;
    logic [prl_pkg::TIME_W-1:0]   r_s0_now;

    logic                         r_s1_vld;
    prl_pkg::t_status             r_s1_st, n_s1_st;
    logic [prl_pkg::CNT_W-1:0]    r_s1_fcnt;
    logic [prl_pkg::TIME_W-1:0]   r_s1_last;
    logic                         r_s1_lock;
    logic [prl_pkg::TIME_W-1:0]   r_s1_now;

    logic                         r_s2_vld;
    prl_pkg::t_status             r_s2_st;
    logic [prl_pkg::DLY_W-1:0]    r_s2_dly;
    logic [prl_pkg::CNT_W-1:0]    r_s2_fcnt;
    logic                         r_s2_lock;

    logic s0_rdy, s1_rdy, s2_rdy, adv0, adv1;
    logic [prl_pkg::PIN_W-1:0]  cur_pin;
    logic [prl_pkg::DLY_W-1:0]  pre_dly;
    logic [prl_pkg::CNT_W-1:0]  inc_fcnt;

    assign s2_rdy = !r_s2_vld || o_rsp.ready;
    assign s1_rdy = !r_s1_vld || s2_rdy;
    assign s0_rdy = !r_s0_vld || s1_rdy;
    assign adv0   = r_s0_vld && s1_rdy;
    assign adv1   = r_s1_vld && s2_rdy;

    assign i_req.ready = s0_rdy;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.factory_pin <= prl_pkg::RST_FACTORY_PIN;
            r_cfg.free_att    <= prl_pkg::RST_FREE_ATT;
            r_cfg.lock_limit  <= prl_pkg::RST_LOCK_LIMIT;
            r_cfg.base_ms     <= prl_pkg::RST_BASE_MS;
            r_cfg.cap_ms      <= prl_pkg::RST_CAP_MS;
        end else if (i_cfg_we) begin
            unique case (prl_pkg::t_cfg_idx'(i_cfg_idx))
                prl_pkg::CFG_FACTORY_PIN: r_cfg.factory_pin <= i_cfg_data;
                prl_pkg::CFG_FREE_ATT:    r_cfg.free_att    <= i_cfg_data[prl_pkg::CNT_W-1:0];
                prl_pkg::CFG_LOCK_LIMIT:  r_cfg.lock_limit  <= i_cfg_data[prl_pkg::CNT_W-1:0];
                prl_pkg::CFG_BASE_MS:     r_cfg.base_ms     <= i_cfg_data[prl_pkg::DLY_W-1:0];
                prl_pkg::CFG_CAP_MS:      r_cfg.cap_ms      <= i_cfg_data[prl_pkg::DLY_W-1:0];
                default: ;
            endcase
        end
    end

    // stage 0: request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (s0_rdy) begin
            r_s0_vld <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s0_rdy && i_req.valid) begin
            r_s0_act <= prl_pkg::t_action'(i_req.action);
            r_s0_pin <= i_req.pin_code;
            r_s0_new <= i_req.new_code;
            r_s0_now <= i_req.now_ms;
        end
    end

    // verify and state update
    assign cur_pin  = r_pin_chg ? r_chg_pin : r_cfg.factory_pin;
    assign pre_dly  = prl_pkg::calc_delay(r_lock, r_fcnt, r_last, r_s0_now, r_cfg);
    assign inc_fcnt = (r_fcnt < prl_pkg::FAIL_MAX) ? r_fcnt + 1'b1 : r_fcnt;

    always_comb begin
        n_s1_st   = prl_pkg::ST_OK;
        n_fcnt    = r_fcnt;
        n_last    = r_last;
        n_lock    = r_lock;
        n_chg_pin = r_chg_pin;
        n_pin_chg = r_pin_chg;
        unique case (r_s0_act)
            prl_pkg::ACT_VERIFY, prl_pkg::ACT_CHANGE: begin
                priority if (r_lock) begin
                    n_s1_st = prl_pkg::ST_LOCKED;
                end else if (pre_dly != '0) begin
                    n_s1_st = prl_pkg::ST_RATE;
                end else if (r_s0_pin == cur_pin) begin
                    n_fcnt = '0;
                    n_last = '0;
                    if (r_s0_act == prl_pkg::ACT_CHANGE) begin
                        if (prl_pkg::pin_fmt_ok(r_s0_new)) begin
                            n_chg_pin = r_s0_new;
                            n_pin_chg = 1'b1;
                        end else begin
                            n_s1_st = prl_pkg::ST_INVALID;
                        end
                    end
                end else begin
                    n_s1_st = prl_pkg::ST_INVALID;
                    n_fcnt  = inc_fcnt;
                    n_last  = r_s0_now;
                    n_lock  = (inc_fcnt >= r_cfg.lock_limit);
                end
            end
            prl_pkg::ACT_CLEAR: begin
                n_fcnt = '0;
                n_last = '0;
                n_lock = 1'b0;
            end
            prl_pkg::ACT_QUERY: begin
                priority if (r_lock) begin
                    n_s1_st = prl_pkg::ST_LOCKED;
                end else if (pre_dly != '0) begin
                    n_s1_st = prl_pkg::ST_RATE;
                end else begin
                    n_s1_st = prl_pkg::ST_OK;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fcnt    <= '0;
            r_last    <= '0;
            r_lock    <= 1'b0;
            r_pin_chg <= 1'b0;
        end else if (adv0) begin
            r_fcnt    <= n_fcnt;
            r_last    <= n_last;
            r_lock    <= n_lock;
            r_pin_chg <= n_pin_chg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv0) begin
            r_chg_pin <= n_chg_pin;
        end
    end

    // stage 1: post-update snapshot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s1_rdy) begin
            r_s1_vld <= r_s0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv0) begin
            r_s1_st   <= n_s1_st;
            r_s1_fcnt <= n_fcnt;
            r_s1_last <= n_last;
            r_s1_lock <= n_lock;
            r_s1_now  <= r_s0_now;
        end
    end

    // stage 2: response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (s2_rdy) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_s2_st   <= r_s1_st;
            r_s2_dly  <= prl_pkg::calc_delay(r_s1_lock, r_s1_fcnt, r_s1_last, r_s1_now,
                                             r_cfg);
            r_s2_fcnt <= r_s1_fcnt;
            r_s2_lock <= r_s1_lock;
        end
    end

    assign o_rsp.valid          = r_s2_vld;
    assign o_rsp.status         = r_s2_st;
    assign o_rsp.retry_delay_ms = r_s2_dly;
    assign o_rsp.failures       = r_s2_fcnt;
    assign o_rsp.locked         = r_s2_lock;

    a_lock_all_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.locked |-> o_rsp.retry_delay_ms == '1)
        else $error("locked response without all-ones delay");

    a_locked_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.status == prl_pkg::ST_LOCKED |-> o_rsp.locked)
        else $error("locked-out status while lock flag is clear");

    a_lock_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lock && !(adv0 && r_s0_act == prl_pkg::ACT_CLEAR) |=> r_lock)
        else $error("lockout released without a clear request");

    a_s0_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s0_vld && !s1_rdy |=> r_s0_vld && $stable(r_s0_now))
        else $error("stalled request lost from stage 0");

    a_fail_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv0 && n_s1_st == prl_pkg::ST_RATE |=> $stable(r_fcnt) && $stable(r_last))
        else $error("rate-limited request changed failure state");

endmodule
